/* design/mwncc_pkg.sv */
// Package for masked_window_ncc_score: payload structs, sizes and constants.
// No dependencies.
package mwncc_pkg;

  localparam int WINDOW_SIDE = 7;
  localparam int PIX_CAP_RAW = WINDOW_SIDE * WINDOW_SIDE;
  localparam int PIX_CAP     = (PIX_CAP_RAW > 63) ? 63 : PIX_CAP_RAW;

  localparam int PIX_W   = 9;
  localparam int CNT_W   = 6;
  localparam int SUM_W   = 15;
  localparam int SQ_W    = 23;
  localparam int PROD_W  = 30;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int RAD_W   = 2 * PROD_W;
  localparam int ROOT_W  = PROD_W;
  localparam int FRAC_W  = 14;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = PROD_W + FRAC_W + 1;
  localparam int SCORE_W = 16;
  localparam int STEP_W  = 5;

  localparam logic [PIX_W-1:0]   MISSING_MARK = PIX_W'(300);
  localparam logic [QUO_W-1:0]   Q_ONE        = QUO_W'(16384);
  localparam logic [CNT_W-1:0]   CNT_CAP      = CNT_W'(PIX_CAP);
  localparam logic [STEP_W-1:0]  SQRT_LAST    = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0]  DIV_LAST     = STEP_W'(QUO_W - 1);

  typedef struct packed {
    logic [PIX_W-1:0] first_red;
    logic [PIX_W-1:0] first_green;
    logic [PIX_W-1:0] first_blue;
    logic [PIX_W-1:0] second_red;
    logic [PIX_W-1:0] second_green;
    logic [PIX_W-1:0] second_blue;
    logic             last_pixel;
  } item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score_red;
    logic signed [SCORE_W-1:0] score_green;
    logic signed [SCORE_W-1:0] score_blue;
    logic [2:0]                degenerate_flags;
    logic [CNT_W-1:0]          used_pixels;
  } result_t;

  typedef struct packed {
    logic                      done;
    logic                      degen;
    logic signed [SCORE_W-1:0] score;
  } lane_res_t;

endpackage

/* design/mwncc_lane.sv */
// One color channel: running sums, then covariance, variance product,
// bit-serial square root and restoring divide. Depends on mwncc_pkg.
module mwncc_lane import mwncc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic             go_i,
  input  logic [PIX_W-1:0] a_i,
  input  logic [PIX_W-1:0] b_i,
  input  logic [CNT_W-1:0] n_i,
  output lane_res_t        res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_PROD = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIVP = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [SUM_W-1:0]   sx_q, sy_q;
  logic [SQ_W-1:0]    sxy_q, sxx_q, syy_q;
  logic [PROD_W-1:0]  nxy_q, nxx_q, nyy_q, pxy_q, pxx_q, pyy_q;
  logic signed [DIFF_W-1:0] cov_q, cov_d, vx_d, vy_d;
  logic [PROD_W-1:0]  vx_q, vy_q, mag;
  logic               degen_q;
  logic [RAD_W-1:0]   rad_q;
  logic [ROOT_W-1:0]  root_q;
  logic [ROOT_W:0]    rem_q;
  logic [ROOT_W+2:0]  sq_t, sq_trial;
  logic [STEP_W-1:0]  cnt_q;
  logic [ROOT_W-1:0]  drem_q;
  logic [ROOT_W:0]    div_t;
  logic [QUO_W-1:0]   numlo_q, quo_q, qsat;
  logic [NUM_W-1:0]   num;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (go_i) state_d = S_MUL;
      S_MUL:  state_d = S_SUB;
      S_SUB:  state_d = S_PROD;
      S_PROD: state_d = S_SQRT;
      S_SQRT: if (cnt_q == '0) state_d = S_DIVP;
      S_DIVP: state_d = S_DIV;
      S_DIV:  if (cnt_q == '0) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
    end else if (state_q == S_FIN) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
    end else if (acc_i) begin
      sx_q  <= sx_q + SUM_W'(a_i);
      sy_q  <= sy_q + SUM_W'(b_i);
      sxy_q <= sxy_q + SQ_W'(a_i * b_i);
      sxx_q <= sxx_q + SQ_W'(a_i * a_i);
      syy_q <= syy_q + SQ_W'(b_i * b_i);
    end
  end

  assign cov_d = DIFF_W'(nxy_q) - DIFF_W'(pxy_q);
  assign vx_d  = DIFF_W'(nxx_q) - DIFF_W'(pxx_q);
  assign vy_d  = DIFF_W'(nyy_q) - DIFF_W'(pyy_q);

  assign sq_t     = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign mag      = cov_q[DIFF_W-1] ? PROD_W'(-cov_q) : PROD_W'(cov_q);
  assign num      = {1'b0, mag, FRAC_W'(0)} + NUM_W'(root_q >> 1);
  assign div_t    = {drem_q, numlo_q[QUO_W-1]};

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MUL: begin
        nxy_q <= PROD_W'(n_i * sxy_q);
        nxx_q <= PROD_W'(n_i * sxx_q);
        nyy_q <= PROD_W'(n_i * syy_q);
        pxy_q <= PROD_W'(sx_q * sy_q);
        pxx_q <= PROD_W'(sx_q * sx_q);
        pyy_q <= PROD_W'(sy_q * sy_q);
      end
      S_SUB: begin
        cov_q   <= cov_d;
        vx_q    <= PROD_W'(vx_d);
        vy_q    <= PROD_W'(vy_d);
        degen_q <= (n_i == '0) || (vx_d <= 0) || (vy_d <= 0);
      end
      S_PROD: begin
        rad_q  <= vx_q * vy_q;
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= SQRT_LAST;
      end
      S_SQRT: begin
        rad_q <= rad_q << 2;
        cnt_q <= cnt_q - 1'b1;
        if (sq_t >= sq_trial) begin
          rem_q  <= (ROOT_W+1)'(sq_t - sq_trial);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= (ROOT_W+1)'(sq_t);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      S_DIVP: begin
        drem_q  <= num[NUM_W-1 -: ROOT_W];
        numlo_q <= num[QUO_W-1:0];
        quo_q   <= '0;
        cnt_q   <= DIV_LAST;
        if (root_q == '0) degen_q <= 1'b1;
      end
      S_DIV: begin
        numlo_q <= numlo_q << 1;
        cnt_q   <= cnt_q - 1'b1;
        if (div_t >= {1'b0, root_q}) begin
          drem_q <= ROOT_W'(div_t - {1'b0, root_q});
          quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          drem_q <= ROOT_W'(div_t);
          quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign qsat = (quo_q > Q_ONE) ? Q_ONE : quo_q;

  always_comb begin
    res_o.done  = (state_q == S_FIN);
    res_o.degen = degen_q;
    if (degen_q) begin
      res_o.score = '0;
    end else if (cov_q[DIFF_W-1]) begin
      res_o.score = -$signed({1'b0, qsat});
    end else begin
      res_o.score = $signed({1'b0, qsat});
    end
  end

endmodule

/* design/masked_window_ncc_score.sv */
// Top level: input screening, pair count, three channel lanes, result merge.
// Depends on mwncc_pkg and mwncc_lane.
// Accumulation: one transaction per cycle while busy is low.
// On a last-pixel transaction busy rises; the result strobe follows acceptance
// once the multiplies, 30-step square root and 15-step divide of each lane are done.
// busy falls with the strobe; the next transaction may start that cycle.
// Reset (rst_ni low, asynchronous) clears all sums, the count and the strobe.
module masked_window_ncc_score import mwncc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    result_valid_o,
  output result_t result_o
);

  logic             accept, use_pair, clear;
  logic             busy_q, valid_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PIX_W-1:0] a_g, a_b, b_g, b_b;
  lane_res_t        res_r, res_g, res_b;
  result_t          out_q;

  assign accept   = start && !busy_q;
  assign use_pair = accept && (item_i.first_red < MISSING_MARK) &&
                    (item_i.second_red < MISSING_MARK) && (cnt_q < CNT_CAP);
  assign clear    = res_r.done;

  assign a_g = (item_i.first_green  > MISSING_MARK) ? MISSING_MARK : item_i.first_green;
  assign a_b = (item_i.first_blue   > MISSING_MARK) ? MISSING_MARK : item_i.first_blue;
  assign b_g = (item_i.second_green > MISSING_MARK) ? MISSING_MARK : item_i.second_green;
  assign b_b = (item_i.second_blue  > MISSING_MARK) ? MISSING_MARK : item_i.second_blue;

  mwncc_lane u_red (
    .clk_i, .rst_ni, .acc_i(use_pair), .go_i(accept && item_i.last_pixel),
    .a_i(item_i.first_red), .b_i(item_i.second_red), .n_i(cnt_q), .res_o(res_r)
  );
  mwncc_lane u_green (
    .clk_i, .rst_ni, .acc_i(use_pair), .go_i(accept && item_i.last_pixel),
    .a_i(a_g), .b_i(b_g), .n_i(cnt_q), .res_o(res_g)
  );
  mwncc_lane u_blue (
    .clk_i, .rst_ni, .acc_i(use_pair), .go_i(accept && item_i.last_pixel),
    .a_i(a_b), .b_i(b_b), .n_i(cnt_q), .res_o(res_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= clear;
      if (clear) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        if (accept && item_i.last_pixel) busy_q <= 1'b1;
        if (use_pair) cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      out_q.score_red        <= res_r.score;
      out_q.score_green      <= res_g.score;
      out_q.score_blue       <= res_b.score;
      out_q.degenerate_flags <= {res_b.degen, res_g.degen, res_r.degen};
      out_q.used_pixels      <= cnt_q;
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = valid_q;
  assign result_o       = out_q;

endmodule

/* design/mwncc_checker.sv */
// Port-level checker for masked_window_ncc_score, bound to the top level.
// Depends on mwncc_pkg.
module mwncc_checker import mwncc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input item_t   item_i,
  input logic    result_valid_o,
  input result_t result_o
);

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.last_pixel |=> busy)
    else $error("busy not raised after last pixel");

  a_fall_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without result");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe repeated");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.degenerate_flags[0] |-> result_o.score_red == '0)
    else $error("degenerate red score not zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.score_green <= 16'sd16384) &&
                       (result_o.score_green >= -16'sd16384))
    else $error("green score out of range");

endmodule

bind masked_window_ncc_score mwncc_checker u_mwncc_checker (.*);
